@@ hw/rtl/nrs_pkg.sv @@
// Shared types, constants and saturation helper for the ReLU/SGD neuron.
`default_nettype none
package nrs_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int LR_W    = 16;
    localparam int ACC_W   = 40;
    localparam int PRE_W   = ACC_W + 1;
    localparam int MUL_A_W = 2 * DATA_W + 1;
    localparam int MUL_B_W = LR_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int W_SHIFT = 2 * FRAC_W + LR_W - FRAC_W;
    localparam int B_SHIFT = LR_W;
    localparam int STEP_W  = PROD_W + 1 - B_SHIFT;
    localparam int SAT_IN_W = PRE_W + 1;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI =
        (SAT_IN_W'(1) <<< (DATA_W - 1)) - SAT_IN_W'(1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -(SAT_IN_W'(1) <<< (DATA_W - 1));

    typedef enum logic [1:0] {
        OP_FWD  = 2'd0,
        OP_BWD  = 2'd1,
        OP_WR_W = 2'd2,
        OP_WR_B = 2'd3
    } op_t;

    localparam logic [1:0] MODE_RELU     = 2'd0;
    localparam logic [1:0] MODE_SOFTMAX  = 2'd1;
    localparam logic [1:0] MODE_PASS     = 2'd2;
    localparam logic [1:0] MODE_PASS_ALT = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LR   = 2'd1;

    typedef enum logic [1:0] {
        MUL_XW   = 2'd0,
        MUL_GX   = 2'd1,
        MUL_LRGX = 2'd2,
        MUL_LRG  = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } sat_t;

    function automatic sat_t sat_data(input logic signed [SAT_IN_W-1:0] v);
        sat_t r;
        if (v > SAT_HI) begin
            r.value = SAT_HI[DATA_W-1:0];
            r.clip  = 1'b1;
        end else if (v < SAT_LO) begin
            r.value = SAT_LO[DATA_W-1:0];
            r.clip  = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nrs_mul.sv @@
// Shared signed multiplier with operand select and registered product.
`default_nettype none
module nrs_mul (
    input  wire logic                                aclk,
    input  wire nrs_pkg::mul_sel_t                   sel,
    input  wire logic signed [nrs_pkg::DATA_W-1:0]   x_val,
    input  wire logic signed [nrs_pkg::DATA_W-1:0]   w_val,
    input  wire logic signed [nrs_pkg::DATA_W-1:0]   grad_val,
    input  wire logic        [nrs_pkg::LR_W-1:0]     lr_val,
    output logic signed      [nrs_pkg::PROD_W-1:0]   prod
);
    import nrs_pkg::*;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_reg;

    always_comb begin
        unique case (sel)
            MUL_XW: begin
                op_a = MUL_A_W'(w_val);
                op_b = MUL_B_W'(x_val);
            end
            MUL_GX: begin
                op_a = MUL_A_W'(x_val);
                op_b = MUL_B_W'(grad_val);
            end
            MUL_LRGX: begin
                op_a = $signed(prod_reg[MUL_A_W-1:0]);
                op_b = $signed({1'b0, lr_val});
            end
            MUL_LRG: begin
                op_a = MUL_A_W'(grad_val);
                op_b = $signed({1'b0, lr_val});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ hw/rtl/nrs_wmem.sv @@
// Weight store: one write port, one registered read port.
`default_nettype none
module nrs_wmem #(
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic [AW-1:0]                     wr_addr,
    input  wire logic [nrs_pkg::DATA_W-1:0]        wr_data,
    input  wire logic                              rd_en,
    input  wire logic [AW-1:0]                     rd_addr,
    output logic      [nrs_pkg::DATA_W-1:0]        rd_data
);
    import nrs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/neuron_relu_sgd_unit.sv @@
// Top level: sequencer, accumulator and update datapath of the ReLU/SGD neuron.
// Forward element: multiply, then accumulate; the last forward element adds pre-activation and result load.
// Backward element: gradient product, rate product, round, weight update; the last adds the bias update.
// Weight/bias write: done on acceptance in idle. One item at a time: input is ready only in idle.
// A result stays in the output register; the next item is taken meanwhile.
// Sync active-low reset clears control, accumulator, bias and configuration registers; weights undefined.
`default_nettype none
module neuron_relu_sgd_unit #(
    parameter int MAX_INPUTS = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_operation,
    input  wire logic [7:0]                        s_element_index,
    input  wire logic signed [nrs_pkg::DATA_W-1:0] s_x_value,
    input  wire logic signed [nrs_pkg::DATA_W-1:0] s_delta_value,
    input  wire logic                              s_last_element,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_result_kind,
    output logic signed [nrs_pkg::DATA_W-1:0]      m_result_value,
    output logic                                   m_saturated,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [nrs_pkg::LR_W-1:0]          cfg_data
);
    import nrs_pkg::*;

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int IW = (AW > 8) ? AW : 8;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_F_MUL  = 12'b0000_0000_0010,
        ST_F_ACC  = 12'b0000_0000_0100,
        ST_F_PRE  = 12'b0000_0000_1000,
        ST_F_OUT  = 12'b0000_0001_0000,
        ST_B_MUL1 = 12'b0000_0010_0000,
        ST_B_MUL2 = 12'b0000_0100_0000,
        ST_B_WRND = 12'b0000_1000_0000,
        ST_B_WUPD = 12'b0001_0000_0000,
        ST_B_MUL3 = 12'b0010_0000_0000,
        ST_B_BRND = 12'b0100_0000_0000,
        ST_B_BUPD = 12'b1000_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      last_reg;
    logic                      in_range_reg;
    logic [AW-1:0]             addr_reg;
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  grad_reg;
    logic [1:0]                mode_reg;
    logic [LR_W-1:0]           lr_reg;
    logic signed [DATA_W-1:0]  bias_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PRE_W-1:0]   pre_reg;
    logic                      preact_pos_reg;
    logic                      clip_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic                      m_valid_reg;
    logic                      m_kind_reg;
    logic [DATA_W-1:0]         m_value_reg;
    logic                      m_sat_reg;

    logic                      accept;
    logic                      go;
    logic                      s_in_range;
    logic [IW-1:0]             s_idx_wide;
    logic [AW-1:0]             s_addr;
    logic signed [DATA_W-1:0]  s_grad;
    mul_sel_t                  mul_sel;
    logic signed [PROD_W-1:0]  prod;
    logic [DATA_W-1:0]         w_rd;
    logic signed [DATA_W-1:0]  w_eff;
    logic signed [PRE_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic                      acc_clip;
    logic signed [PRE_W-1:0]   pre_sum;
    logic signed [SAT_IN_W-1:0] fwd_rnd;
    sat_t                      fwd_sat;
    logic [DATA_W-1:0]         fwd_val;
    logic signed [PROD_W:0]    w_rnd;
    logic signed [PROD_W:0]    b_rnd;
    logic signed [DATA_W-1:0]  upd_base;
    logic signed [SAT_IN_W-1:0] upd_diff;
    sat_t                      upd_sat;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [DATA_W-1:0]         mem_wdata;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign go         = !m_valid_reg || m_ready;
    assign cfg_ready  = 1'b1;
    assign s_idx_wide = IW'(s_element_index);
    assign s_addr     = s_idx_wide[AW-1:0];
    assign s_in_range = (32'(s_element_index) < 32'(MAX_INPUTS));

    always_comb begin
        if (mode_reg == MODE_RELU) begin
            s_grad = preact_pos_reg ? s_delta_value : '0;
        end else if (mode_reg == MODE_SOFTMAX) begin
            s_grad = s_delta_value;
        end else begin
            s_grad = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_FWD) begin
                    state_next = ST_F_MUL;
                end else if (accept && s_operation == OP_BWD) begin
                    state_next = ST_B_MUL1;
                end
            end
            ST_F_MUL:  state_next = ST_F_ACC;
            ST_F_ACC:  state_next = last_reg ? ST_F_PRE : ST_IDLE;
            ST_F_PRE:  state_next = ST_F_OUT;
            ST_F_OUT:  state_next = go ? ST_IDLE : ST_F_OUT;
            ST_B_MUL1: state_next = ST_B_MUL2;
            ST_B_MUL2: state_next = ST_B_WRND;
            ST_B_WRND: state_next = ST_B_WUPD;
            ST_B_WUPD: state_next = last_reg ? ST_B_MUL3 : ST_IDLE;
            ST_B_MUL3: state_next = ST_B_BRND;
            ST_B_BRND: state_next = ST_B_BUPD;
            ST_B_BUPD: state_next = go ? ST_IDLE : ST_B_BUPD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_B_MUL1: mul_sel = MUL_GX;
            ST_B_MUL2: mul_sel = MUL_LRGX;
            ST_B_MUL3: mul_sel = MUL_LRG;
            default:   mul_sel = MUL_XW;
        endcase
    end

    assign w_eff = in_range_reg ? $signed(w_rd) : '0;

    nrs_mul u_mul (
        .aclk     (aclk),
        .sel      (mul_sel),
        .x_val    (x_reg),
        .w_val    (w_eff),
        .grad_val (grad_reg),
        .lr_val   (lr_reg),
        .prod     (prod)
    );

    // datapath
    always_comb begin
        acc_sum = PRE_W'(acc_reg) + PRE_W'($signed(prod[2*DATA_W-1:0]));
        if (acc_sum[PRE_W-1] != acc_sum[ACC_W-1]) begin
            acc_clip = 1'b1;
            acc_sat  = acc_sum[PRE_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_clip = 1'b0;
            acc_sat  = acc_sum[ACC_W-1:0];
        end

        pre_sum = PRE_W'(acc_reg) + PRE_W'($signed({bias_reg, {FRAC_W{1'b0}}}));

        fwd_rnd = SAT_IN_W'(pre_reg) + (SAT_IN_W'(1) <<< (FRAC_W - 1));
        fwd_sat = sat_data(SAT_IN_W'($signed(fwd_rnd[SAT_IN_W-1:FRAC_W])));
        if (mode_reg == MODE_RELU && fwd_sat.value[DATA_W-1]) begin
            fwd_val = '0;
        end else begin
            fwd_val = fwd_sat.value;
        end

        w_rnd = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< (W_SHIFT - 1));
        b_rnd = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< (B_SHIFT - 1));

        upd_base = (state_reg == ST_B_WUPD) ? $signed(w_rd) : bias_reg;
        upd_diff = SAT_IN_W'(upd_base) - SAT_IN_W'(step_reg);
        upd_sat  = sat_data(upd_diff);
    end

    assign mem_we    = (accept && s_operation == OP_WR_W && s_in_range)
                     || (state_reg == ST_B_WUPD && in_range_reg);
    assign mem_waddr = (state_reg == ST_B_WUPD) ? addr_reg : s_addr;
    assign mem_wdata = (state_reg == ST_B_WUPD) ? upd_sat.value : s_x_value;

    nrs_wmem #(
        .DEPTH (MAX_INPUTS)
    ) u_wmem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (s_addr),
        .rd_data (w_rd)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_RELU;
            lr_reg         <= '0;
            bias_reg       <= '0;
            acc_reg        <= '0;
            preact_pos_reg <= 1'b0;
            clip_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_LR:   lr_reg <= cfg_data;
                    default:  ;
                endcase
            end

            if (accept && s_operation == OP_WR_B) begin
                bias_reg <= s_x_value;
            end

            if (state_reg == ST_F_ACC) begin
                acc_reg <= acc_sat;
                if (acc_clip) begin
                    clip_reg <= 1'b1;
                end
            end

            if (state_reg == ST_F_PRE) begin
                preact_pos_reg <= (pre_sum > 0);
            end

            if (state_reg == ST_B_WUPD && in_range_reg && upd_sat.clip) begin
                clip_reg <= 1'b1;
            end

            if (state_reg == ST_F_OUT && go) begin
                acc_reg     <= '0;
                clip_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (state_reg == ST_B_BUPD && go) begin
                bias_reg    <= $signed(upd_sat.value);
                clip_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg     <= s_last_element;
            in_range_reg <= s_in_range;
            addr_reg     <= s_addr;
            x_reg        <= s_x_value;
            grad_reg     <= s_grad;
        end
        if (state_reg == ST_F_PRE) begin
            pre_reg <= pre_sum;
        end
        if (state_reg == ST_B_WRND) begin
            step_reg <= STEP_W'($signed(w_rnd[PROD_W:W_SHIFT]));
        end else if (state_reg == ST_B_BRND) begin
            step_reg <= $signed(b_rnd[PROD_W:B_SHIFT]);
        end
        if (state_reg == ST_F_OUT && go) begin
            m_kind_reg  <= 1'b0;
            m_value_reg <= fwd_val;
            m_sat_reg   <= clip_reg | fwd_sat.clip;
        end else if (state_reg == ST_B_BUPD && go) begin
            m_kind_reg  <= 1'b1;
            m_value_reg <= upd_sat.value;
            m_sat_reg   <= clip_reg | upd_sat.clip;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_result_value = $signed(m_value_reg);
    assign m_saturated    = m_sat_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_F_OUT || state_reg == ST_B_BUPD))
        else $error("result raised outside a finishing state");

    a_mem_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_B_WUPD))
        else $error("weight write from unexpected state");

    a_fwd_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_F_ACC && !last_reg) |=> (state_reg == ST_IDLE))
        else $error("non-last forward element did not return to idle");

endmodule
`default_nettype wire

@@ test/neuron_relu_sgd_checker.sv @@
// Checker for the ReLU/SGD neuron: predicts each result from observed transfers and compares.
`timescale 1ns / 100ps
module neuron_relu_sgd_checker #(
    parameter int MAX_INPUTS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic [7:0]                        s_element_index,
    input  logic signed [nrs_pkg::DATA_W-1:0] s_x_value,
    input  logic signed [nrs_pkg::DATA_W-1:0] s_delta_value,
    input  logic                              s_last_element,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_result_kind,
    input  logic signed [nrs_pkg::DATA_W-1:0] m_result_value,
    input  logic                              m_saturated,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [nrs_pkg::LR_W-1:0]          cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);
    import nrs_pkg::*;

    localparam bit KIND_ACT  = 1'b0;
    localparam bit KIND_BIAS = 1'b1;

    typedef struct {
        bit                kind;
        logic [DATA_W-1:0] value;
        bit                sat;
    } neuron_out_t;

    neuron_out_t               neuron_out_q[$];
    logic signed [DATA_W-1:0]  weight_mem[MAX_INPUTS];
    longint                    bias_q;
    longint                    acc;
    bit                        pre_pos;
    bit                        clip_flag;
    logic [1:0]                act_mode;
    longint                    step_rate;

    function automatic longint saturate(longint v, int bits, inout bit clip);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -(longint'(1) <<< (bits - 1));
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint round_half_up(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    task automatic compute_neuron_out(op_t op, logic [7:0] idx, logic signed [DATA_W-1:0] x,
                                      logic signed [DATA_W-1:0] d, bit last);
        longint      xv;
        longint      w;
        longint      pre;
        longint      val;
        longint      grad;
        longint      wstep;
        neuron_out_t r;
        xv = longint'(x);
        w  = (idx < MAX_INPUTS) ? longint'(weight_mem[idx]) : 0;
        case (op)
            OP_WR_W: begin
                if (idx < MAX_INPUTS)
                    weight_mem[idx] = x;
            end
            OP_WR_B: begin
                bias_q = xv;
            end
            OP_FWD: begin
                acc = saturate(acc + xv * w, ACC_W, clip_flag);
                if (last) begin
                    pre     = acc + (bias_q <<< FRAC_W);
                    pre_pos = pre > 0;
                    val     = saturate(round_half_up(pre, FRAC_W), DATA_W, clip_flag);
                    if (act_mode == MODE_RELU && val < 0)
                        val = 0;
                    r.kind  = KIND_ACT;
                    r.value = val[DATA_W-1:0];
                    r.sat   = clip_flag;
                    neuron_out_q.push_back(r);
                    acc       = 0;
                    clip_flag = 1'b0;
                end
            end
            default: begin
                if (act_mode == MODE_RELU)
                    grad = pre_pos ? longint'(d) : 0;
                else if (act_mode == MODE_SOFTMAX)
                    grad = longint'(d);
                else
                    grad = 0;
                if (idx < MAX_INPUTS) begin
                    wstep = round_half_up(step_rate * (grad * xv), W_SHIFT);
                    weight_mem[idx] = DATA_W'(saturate(w - wstep, DATA_W, clip_flag));
                end
                if (last) begin
                    bias_q = saturate(bias_q - round_half_up(step_rate * grad, B_SHIFT),
                                      DATA_W, clip_flag);
                    r.kind  = KIND_BIAS;
                    r.value = bias_q[DATA_W-1:0];
                    r.sat   = clip_flag;
                    neuron_out_q.push_back(r);
                    clip_flag = 1'b0;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        neuron_out_t e;
        if (!aresetn) begin
            neuron_out_q.delete();
            fail_count = 0;
            checked    = 0;
            bias_q     = 0;
            acc        = 0;
            pre_pos    = 1'b0;
            clip_flag  = 1'b0;
            act_mode   = MODE_RELU;
            step_rate  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MODE)
                    act_mode = cfg_data[1:0];
                else if (cfg_index == REG_LR)
                    step_rate = longint'(cfg_data);
            end
            if (m_valid && m_ready) begin
                checked++;
                if (neuron_out_q.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d", m_result_kind,
                           m_result_value);
                    fail_count++;
                end else begin
                    e = neuron_out_q.pop_front();
                    if (m_result_kind !== e.kind) begin
                        $error("result_kind: expected %0d, got %0d", e.kind, m_result_kind);
                        fail_count++;
                    end
                    if (m_result_value !== e.value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(e.value), m_result_value);
                        fail_count++;
                    end
                    if (m_saturated !== e.sat) begin
                        $error("saturated: expected %0d, got %0d", e.sat, m_saturated);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                compute_neuron_out(op_t'(s_operation), s_element_index, s_x_value,
                                   s_delta_value, s_last_element);
        end
        pending = neuron_out_q.size();
    end

endmodule

@@ test/neuron_relu_sgd_unit_tb.sv @@
// Testbench top for the ReLU/SGD neuron: clock, reset, stimulus, and the final verdict.
`timescale 1ns / 100ps
module neuron_relu_sgd_unit_tb;
    import nrs_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_operation = OP_WR_B;
    logic [7:0]               s_element_index = '0;
    logic signed [DATA_W-1:0] s_x_value = '0;
    logic signed [DATA_W-1:0] s_delta_value = '0;
    logic                     s_last_element = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_result_kind;
    logic signed [DATA_W-1:0] m_result_value;
    logic                     m_saturated;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = REG_MODE;
    logic [LR_W-1:0]          cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int n_items;
    int n_cfg;
    bit no_gaps;
    bit weight_known[256];
    int known_idx[$];

    neuron_relu_sgd_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_element_index (s_element_index),
        .s_x_value       (s_x_value),
        .s_delta_value   (s_delta_value),
        .s_last_element  (s_last_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_result_value  (m_result_value),
        .m_saturated     (m_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    neuron_relu_sgd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_element_index (s_element_index),
        .s_x_value       (s_x_value),
        .s_delta_value   (s_delta_value),
        .s_last_element  (s_last_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_result_value  (m_result_value),
        .m_saturated     (m_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk)
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 35);

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [15:0] rand_q16();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'(signed'(16'($urandom_range(0, 8191))) - 16'sd4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // caller enters and leaves at a falling edge
    task automatic push_item(op_t op, logic [7:0] idx, logic [15:0] x, logic [15:0] d,
                             bit last);
        while (!no_gaps && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_element_index <= idx;
        s_x_value       <= x;
        s_delta_value   <= d;
        s_last_element  <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_items++;
    endtask

    task automatic write_weight(logic [7:0] idx, logic [15:0] x);
        push_item(OP_WR_W, idx, x, 16'($urandom), 1'($urandom));
        if (!weight_known[idx]) begin
            weight_known[idx] = 1'b1;
            known_idx.push_back(int'(idx));
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        n_cfg++;
    endtask

    // drain all results, then allow for an item still in flight with no result
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic run_pass();
        logic [7:0]  pidx[16];
        logic [15:0] px[16];
        int          len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            pidx[i] = 8'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
            px[i]   = rand_q16();
            push_item(OP_FWD, pidx[i], px[i], 16'($urandom), i == len - 1);
        end
        if ($urandom_range(0, 9) < 7) begin
            for (int i = 0; i < len; i++)
                push_item(OP_BWD, pidx[i], px[i], rand_q16(), i == len - 1);
        end
    endtask

    task automatic run_random(int quota);
        int start;
        int pick;
        start = n_items;
        while (n_items - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                write_weight(8'($urandom), rand_q16());
            else if (pick < 14)
                push_item(OP_WR_B, 8'($urandom), rand_q16(), 16'($urandom), 1'($urandom));
            else if (pick < 80)
                run_pass();
            else
                push_item($urandom_range(0, 1) ? OP_BWD : OP_FWD,
                          8'(known_idx[$urandom_range(0, known_idx.size() - 1)]),
                          rand_q16(), rand_q16(), $urandom_range(0, 9) < 3);
        end
    endtask

    initial begin
        logic [1:0]  mode_set[6];
        logic [15:0] rate_set[6];
        mode_set = '{MODE_SOFTMAX, MODE_RELU, MODE_PASS, MODE_PASS_ALT, MODE_RELU,
                     MODE_SOFTMAX};
        rate_set = '{16'($urandom), 16'h0000, 16'($urandom), 16'hFFFF, 16'h0001,
                     16'($urandom)};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_MODE, MODE_RELU);
        write_reg(REG_LR, 16'hFFFF);

        // directed: extremes, saturation, ReLU clamp, gradient gating, index bit patterns
        write_weight(8'd0, 16'h7FFF);
        write_weight(8'd255, 16'h8000);
        write_weight(8'd128, 16'h1000);
        push_item(OP_WR_B, 8'd7, 16'h7FFF, 16'h0000, 1'b1);
        push_item(OP_FWD, 8'd0, 16'h7FFF, 16'h0000, 1'b0);
        push_item(OP_FWD, 8'd255, 16'h8000, 16'h0000, 1'b0);
        push_item(OP_FWD, 8'd128, 16'h1000, 16'h0000, 1'b1);
        push_item(OP_BWD, 8'd0, 16'h7FFF, 16'h7FFF, 1'b0);
        push_item(OP_BWD, 8'd255, 16'h8000, 16'h8000, 1'b0);
        push_item(OP_BWD, 8'd128, 16'h1000, 16'h7FFF, 1'b1);
        push_item(OP_WR_B, 8'd255, 16'h8000, 16'hFFFF, 1'b0);
        push_item(OP_FWD, 8'd128, 16'h8000, 16'h0000, 1'b1);
        push_item(OP_BWD, 8'd128, 16'd12345, 16'h8000, 1'b1);
        push_item(OP_FWD, 8'd0, 16'h0000, 16'hFFFF, 1'b1);
        push_item(OP_BWD, 8'd0, 16'hFFFF, 16'h0001, 1'b1);
        write_weight(8'h55, 16'hFFFF);
        write_weight(8'hAA, 16'h0001);
        push_item(OP_FWD, 8'h55, 16'h0001, 16'h0000, 1'b0);
        push_item(OP_FWD, 8'hAA, 16'hFFFF, 16'h0000, 1'b1);
        push_item(OP_BWD, 8'h55, 16'h8000, 16'h8000, 1'b1);
        settle();

        for (int p = 0; p < 6; p++) begin
            no_gaps = (p == 2);
            write_reg(REG_MODE, mode_set[p]);
            write_reg(REG_LR, rate_set[p]);
            run_random(90);
            settle();
        end
        no_gaps = 1'b0;

        $display("Covered %0d input transfers and %0d checked results", n_items, checked);
        $display("over %0d register writes, all activation modes and rate extremes", n_cfg);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
